// ----- hdl/toiir_pkg.sv -----
// ----------------------------------------------------------------------------
// toiir_pkg
// Shared widths, register indexes, reset values and types of the third-order
// recursive filter.
// ----------------------------------------------------------------------------
package toiir_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 32;
   localparam int NUM_COEFS       = 6;
   localparam int CSR_INDEX_WIDTH = $clog2(NUM_COEFS);

   // Exact product, and a sum of six products with headroom
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;
   localparam int FRAC_SHIFT = COEF_WIDTH - 5;
   localparam int Q_WIDTH    = ACC_WIDTH - FRAC_SHIFT;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FF_COEF_0 = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FF_COEF_1 = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FF_COEF_2 = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_COEF_1 = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_COEF_2 = CSR_INDEX_WIDTH'(4);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_COEF_3 = CSR_INDEX_WIDTH'(5);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;

   // Reset coefficients, Q4.27
   localparam coef_type FF_COEF_0_RESET = COEF_WIDTH'(13422);
   localparam coef_type FF_COEF_1_RESET = COEF_WIDTH'(6073352);
   localparam coef_type FF_COEF_2_RESET = COEF_WIDTH'(13422);
   localparam coef_type FB_COEF_1_RESET = COEF_WIDTH'(0);
   localparam coef_type FB_COEF_2_RESET = COEF_WIDTH'(3127273);
   localparam coef_type FB_COEF_3_RESET = COEF_WIDTH'(13422);

   typedef struct packed {
      coef_type ff_coef_0;
      coef_type ff_coef_1;
      coef_type ff_coef_2;
      coef_type fb_coef_1;
      coef_type fb_coef_2;
      coef_type fb_coef_3;
   } coef_bank_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
      sample_type y3;
   } history_type;

endpackage

// ----- hdl/third_order_iir_filter_top.sv -----
// ----------------------------------------------------------------------------
// third_order_iir_filter_top
// Direct form I third-order recursive filter, one output sample per input.
// A sample that transfers is held in the input stage; when the result stage
//   frees up, its result is written there and shown on rsp_valid.
// Throughput: 1 sample per cycle while rsp_ready is high; feedback y[n-1] ->
//   y[n] closes combinationally through the six multipliers and adder tree.
// Reset: clears both delay lines and the stage valids, and loads the
//   default coefficients. No clearing pass; ready right after reset.
// ----------------------------------------------------------------------------
module third_order_iir_filter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // input sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [toiir_pkg::SAMPLE_WIDTH-1:0]    req_sample_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [toiir_pkg::SAMPLE_WIDTH-1:0]    rsp_sample_out,
   // coefficient write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [toiir_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [toiir_pkg::COEF_WIDTH-1:0]      csr_data
);
   import toiir_pkg::*;

   // Input stage: holds the sample waiting to be filtered
   logic          stage_valid_ff;
   logic          stage_valid_in;
   sample_type    stage_sample_ff;

   // Result stage: holds a finished sample until the consumer takes it
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sample_type    rsp_sample_ff;

   // Delay lines x[n-1], x[n-2], y[n-1..3]
   history_type   hist_ff;
   history_type   hist_in;

   coef_bank_type coefs;
   sample_type    filtered;
   logic          advance;
   logic          req_xfer;
   logic          commit;

   // Coefficient writes are always taken
   assign csr_ready = 1'b1;

   toiir_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coefs     (coefs)
   );

   toiir_datapath u_datapath (
      .sample (stage_sample_ff),
      .hist   (hist_ff),
      .coefs  (coefs),
      .result (filtered)
   );

   // The result register frees up when empty or when its sample transfers out
   assign advance   = !rsp_valid_ff || rsp_ready;
   // Take a new sample while the input stage is empty or moving on
   assign req_ready = !stage_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   // A sample finishes: write its result and shift the delay lines
   assign commit    = stage_valid_ff && advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_xfer) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      rsp_valid_in = advance ? stage_valid_ff : rsp_valid_ff;

      // Advance the delay lines only when a sample completes
      hist_in = hist_ff;
      if (commit) begin
         hist_in.x2 = hist_ff.x1;
         hist_in.x1 = stage_sample_ff;
         hist_in.y3 = hist_ff.y2;
         hist_in.y2 = hist_ff.y1;
         hist_in.y1 = filtered;
      end
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hist_ff        <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         hist_ff        <= hist_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_sample_ff <= req_sample_in;
      end
      if (commit) begin
         rsp_sample_ff <= filtered;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

// ----- hdl/toiir_coef_regs.sv -----
// ----------------------------------------------------------------------------
// toiir_coef_regs
// Coefficient register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module toiir_coef_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [toiir_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [toiir_pkg::COEF_WIDTH-1:0]      csr_data,
   output toiir_pkg::coef_bank_type              coefs
);
   import toiir_pkg::*;

   coef_bank_type coefs_ff;
   coef_bank_type coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FF_COEF_0: coefs_in.ff_coef_0 = csr_data;
            CSR_FF_COEF_1: coefs_in.ff_coef_1 = csr_data;
            CSR_FF_COEF_2: coefs_in.ff_coef_2 = csr_data;
            CSR_FB_COEF_1: coefs_in.fb_coef_1 = csr_data;
            CSR_FB_COEF_2: coefs_in.fb_coef_2 = csr_data;
            CSR_FB_COEF_3: coefs_in.fb_coef_3 = csr_data;
            default: ;  // drop writes beyond the bank
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.ff_coef_0 <= FF_COEF_0_RESET;
         coefs_ff.ff_coef_1 <= FF_COEF_1_RESET;
         coefs_ff.ff_coef_2 <= FF_COEF_2_RESET;
         coefs_ff.fb_coef_1 <= FB_COEF_1_RESET;
         coefs_ff.fb_coef_2 <= FB_COEF_2_RESET;
         coefs_ff.fb_coef_3 <= FB_COEF_3_RESET;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

// ----- hdl/toiir_datapath.sv -----
// ----------------------------------------------------------------------------
// toiir_datapath
// Six parallel products, sum, round half up and saturate to one sample.
// ----------------------------------------------------------------------------
module toiir_datapath (
   input  toiir_pkg::sample_type    sample,
   input  toiir_pkg::history_type   hist,
   input  toiir_pkg::coef_bank_type coefs,
   output toiir_pkg::sample_type    result
);
   import toiir_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      ACC_WIDTH'(1) << (FRAC_SHIFT - 1);

   logic signed [PROD_WIDTH-1:0] prod [NUM_COEFS];
   logic signed [ACC_WIDTH-1:0]  prod_ext [NUM_COEFS];
   logic signed [ACC_WIDTH-1:0]  acc;
   logic signed [ACC_WIDTH-1:0]  rounded;
   logic [Q_WIDTH-1:0]           q;
   logic                         fits;

   assign prod[0] = PROD_WIDTH'(sample  * coefs.ff_coef_0);
   assign prod[1] = PROD_WIDTH'(hist.x1 * coefs.ff_coef_1);
   assign prod[2] = PROD_WIDTH'(hist.x2 * coefs.ff_coef_2);
   assign prod[3] = PROD_WIDTH'(hist.y1 * coefs.fb_coef_1);
   assign prod[4] = PROD_WIDTH'(hist.y2 * coefs.fb_coef_2);
   assign prod[5] = PROD_WIDTH'(hist.y3 * coefs.fb_coef_3);

   always_comb begin
      for (int i = 0; i < NUM_COEFS; i++) begin
         prod_ext[i] = {{(ACC_WIDTH - PROD_WIDTH){prod[i][PROD_WIDTH-1]}}, prod[i]};
      end
   end

   // Balanced adder tree; the sum never leaves the accumulator range
   assign acc = ((prod_ext[0] + prod_ext[1]) + (prod_ext[2] + prod_ext[3]))
              + (prod_ext[4] + prod_ext[5]);

   assign rounded = acc + ROUND_BIAS;
   assign q       = rounded[ACC_WIDTH-1:FRAC_SHIFT];

   // In range when all bits above the sample sign agree with it
   assign fits = (q[Q_WIDTH-1:SAMPLE_WIDTH-1] == '0) ||
                 (q[Q_WIDTH-1:SAMPLE_WIDTH-1] == '1);

   always_comb begin
      if (fits) begin
         result = q[SAMPLE_WIDTH-1:0];
      end else if (q[Q_WIDTH-1]) begin
         result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

endmodule
